// ===== src/quaternion_to_euler_angles_core_defines.svh =====
// Assertion macros used by the checker file q2e_checker.sv.
`ifndef QUATERNION_TO_EULER_ANGLES_CORE_DEFINES_SVH
`define QUATERNION_TO_EULER_ANGLES_CORE_DEFINES_SVH

`define Q2E_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("q2e assertion failed");

`define Q2E_ASSERT_DLY(lbl, clk, rstn, ante, dly, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> ##dly (cons)) \
    else $error("q2e latency assertion failed");

`endif

// ===== src/q2e_pkg.sv =====
`default_nettype none
package q2e_pkg;

  localparam int QuatW           = 16;
  localparam int ProdW           = 32;
  localparam int TermW           = 34;
  localparam int CordW           = 36;
  localparam int ZW              = 34;
  localparam int AngW            = 18;
  localparam int OutW            = 16;
  localparam int AtanLen         = 24;
  localparam int DefCordicStages = 16;
  localparam int SqrtSteps       = 29;
  localparam int RadW            = 57;
  localparam int RootW           = 29;
  localparam int RemW            = 59;
  localparam int SinpW           = 30;

  localparam logic signed [TermW-1:0] OneQ28 = 34'sd268435456;
  localparam logic signed [ZW-1:0]    PiZ    = 34'sd2147483648;

  function automatic logic [31:0] atan_lut(input int unsigned idx);
    logic [31:0] v;
    case (idx)
      0:  v = 32'h20000000;
      1:  v = 32'h12E4051E;
      2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;
      4:  v = 32'h028B0D43;
      5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;
      7:  v = 32'h00517C55;
      8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;
      10: v = 32'h000A2F98;
      11: v = 32'h000517CC;
      12: v = 32'h00028BE6;
      13: v = 32'h000145F3;
      14: v = 32'h0000A2F9;
      15: v = 32'h0000517D;
      16: v = 32'h000028BE;
      17: v = 32'h0000145F;
      18: v = 32'h00000A30;
      19: v = 32'h00000518;
      20: v = 32'h0000028C;
      21: v = 32'h00000146;
      22: v = 32'h000000A3;
      23: v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== src/quaternion_to_euler_angles_core.sv =====
// Channel   Signals                                          Direction
// request   start_i, busy_o, quat_w_i .. quat_z_i            in
// result    done_o, roll/pitch/yaw_angle_o, pitch_clamped_o  out
//
// A request is taken in every cycle; busy_o stays low.
// The result passes through the six input stages, the 29-step square root,
// the CORDIC pipeline and an output register.
// done_o is high for one cycle per result and cannot be stalled.
// Reset clears only the valid bits of the pipeline.
`default_nettype none
module quaternion_to_euler_angles_core #(
  parameter int CORDIC_STAGES = q2e_pkg::DefCordicStages
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start_i,
  output logic                                    busy_o,
  input  wire logic signed [q2e_pkg::QuatW-1:0]   quat_w_i,
  input  wire logic signed [q2e_pkg::QuatW-1:0]   quat_x_i,
  input  wire logic signed [q2e_pkg::QuatW-1:0]   quat_y_i,
  input  wire logic signed [q2e_pkg::QuatW-1:0]   quat_z_i,
  output logic                                    done_o,
  output logic signed [q2e_pkg::OutW-1:0]         roll_angle_o,
  output logic signed [q2e_pkg::OutW-1:0]         pitch_angle_o,
  output logic signed [q2e_pkg::OutW-1:0]         yaw_angle_o,
  output logic                                    pitch_clamped_o
);

  localparam int ProdW  = q2e_pkg::ProdW;
  localparam int TermW  = q2e_pkg::TermW;
  localparam int CordW  = q2e_pkg::CordW;
  localparam int SinpW  = q2e_pkg::SinpW;
  localparam int RadW   = q2e_pkg::RadW;
  localparam int AngW   = q2e_pkg::AngW;
  localparam int OutW   = q2e_pkg::OutW;
  localparam int SqrtDly = 3 + q2e_pkg::SqrtSteps;

  logic v0_q, v1_q, v2_q, v3_q, v4_q, v5_q;
  logic signed [q2e_pkg::QuatW-1:0] w_q, x_q, y_q, z_q;
  logic signed [ProdW-1:0] wx_q, yz_q, xx_q, yy_q, wy_q, zx_q, wz_q, xy_q, zz_q;
  logic signed [TermW-1:0] sinr_q, cosr_q, sinp_q, siny_q, cosy_q;
  logic signed [SinpW-1:0] sinp3_q, sinp4_q, sinp5_q;
  logic clamp3_q, clamp4_q, clamp5_q;
  logic signed [2*SinpW-1:0] sq4_q;
  logic [RadW-1:0] rad5_q;

  logic signed [ProdW:0] s_sinr, s_cosr, s_sinp, s_siny, s_cosy;

  logic                   sq_v;
  logic [q2e_pkg::RootW-1:0] sq_root;
  logic [SinpW:0]         sq_tag;

  logic                   p_v;
  logic signed [AngW-1:0] p_ang, r_ang, y_ang;
  logic                   p_tag;

  logic [OutW-1:0] roll_dly_q [0:SqrtDly-1];
  logic [OutW-1:0] yaw_dly_q  [0:SqrtDly-1];

  logic                   done_q, clamp_out_q;
  logic signed [OutW-1:0] roll_q, pitch_q, yaw_q, pitch_sat;

  assign s_sinr = {wx_q[ProdW-1], wx_q} + {yz_q[ProdW-1], yz_q};
  assign s_cosr = {xx_q[ProdW-1], xx_q} + {yy_q[ProdW-1], yy_q};
  assign s_sinp = {wy_q[ProdW-1], wy_q} - {zx_q[ProdW-1], zx_q};
  assign s_siny = {wz_q[ProdW-1], wz_q} + {xy_q[ProdW-1], xy_q};
  assign s_cosy = {yy_q[ProdW-1], yy_q} + {zz_q[ProdW-1], zz_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q   <= 1'b0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      v5_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v0_q   <= start_i;
      v1_q   <= v0_q;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      v4_q   <= v3_q;
      v5_q   <= v4_q;
      done_q <= p_v;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q <= quat_w_i;
    x_q <= quat_x_i;
    y_q <= quat_y_i;
    z_q <= quat_z_i;

    wx_q <= w_q * x_q;
    yz_q <= y_q * z_q;
    xx_q <= x_q * x_q;
    yy_q <= y_q * y_q;
    wy_q <= w_q * y_q;
    zx_q <= z_q * x_q;
    wz_q <= w_q * z_q;
    xy_q <= x_q * y_q;
    zz_q <= z_q * z_q;

    sinr_q <= {s_sinr, 1'b0};
    cosr_q <= q2e_pkg::OneQ28 - {s_cosr, 1'b0};
    sinp_q <= {s_sinp, 1'b0};
    siny_q <= {s_siny, 1'b0};
    cosy_q <= q2e_pkg::OneQ28 - {s_cosy, 1'b0};

    if (sinp_q > q2e_pkg::OneQ28) begin
      sinp3_q  <= q2e_pkg::OneQ28[SinpW-1:0];
      clamp3_q <= 1'b1;
    end else if (sinp_q < -q2e_pkg::OneQ28) begin
      sinp3_q  <= SinpW'(-q2e_pkg::OneQ28);
      clamp3_q <= 1'b1;
    end else begin
      sinp3_q  <= sinp_q[SinpW-1:0];
      clamp3_q <= 1'b0;
    end

    sq4_q    <= sinp3_q * sinp3_q;
    sinp4_q  <= sinp3_q;
    clamp4_q <= clamp3_q;

    rad5_q   <= {1'b1, {(RadW-1){1'b0}}} - sq4_q[RadW-1:0];
    sinp5_q  <= sinp4_q;
    clamp5_q <= clamp4_q;
  end

  q2e_isqrt #(
    .TAG_W(SinpW + 1)
  ) u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(v5_q),
    .rad_i  (rad5_q),
    .tag_i  ({clamp5_q, sinp5_q}),
    .valid_o(sq_v),
    .root_o (sq_root),
    .tag_o  (sq_tag)
  );

  q2e_cordic #(
    .STAGES(CORDIC_STAGES),
    .TAG_W (1)
  ) u_cordic_pitch (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(sq_v),
    .y_i    ({{(CordW-SinpW){sq_tag[SinpW-1]}}, sq_tag[SinpW-1:0]}),
    .x_i    ({{(CordW-q2e_pkg::RootW){1'b0}}, sq_root}),
    .tag_i  (sq_tag[SinpW]),
    .valid_o(p_v),
    .angle_o(p_ang),
    .tag_o  (p_tag)
  );

  q2e_cordic #(
    .STAGES(CORDIC_STAGES),
    .TAG_W (1)
  ) u_cordic_roll (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(v2_q),
    .y_i    ({{(CordW-TermW){sinr_q[TermW-1]}}, sinr_q}),
    .x_i    ({{(CordW-TermW){cosr_q[TermW-1]}}, cosr_q}),
    .tag_i  (1'b0),
    .valid_o(),
    .angle_o(r_ang),
    .tag_o  ()
  );

  q2e_cordic #(
    .STAGES(CORDIC_STAGES),
    .TAG_W (1)
  ) u_cordic_yaw (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(v2_q),
    .y_i    ({{(CordW-TermW){siny_q[TermW-1]}}, siny_q}),
    .x_i    ({{(CordW-TermW){cosy_q[TermW-1]}}, cosy_q}),
    .tag_i  (1'b0),
    .valid_o(),
    .angle_o(y_ang),
    .tag_o  ()
  );

  always_ff @(posedge clk_i) begin
    roll_dly_q[0] <= r_ang[OutW-1:0];
    yaw_dly_q[0]  <= y_ang[OutW-1:0];
    for (int k = 1; k < SqrtDly; k++) begin
      roll_dly_q[k] <= roll_dly_q[k-1];
      yaw_dly_q[k]  <= yaw_dly_q[k-1];
    end
  end

  always_comb begin
    if (p_ang > 18'sd16384) begin
      pitch_sat = 16'sd16384;
    end else if (p_ang < -18'sd16384) begin
      pitch_sat = -16'sd16384;
    end else begin
      pitch_sat = p_ang[OutW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    roll_q      <= roll_dly_q[SqrtDly-1];
    yaw_q       <= yaw_dly_q[SqrtDly-1];
    pitch_q     <= pitch_sat;
    clamp_out_q <= p_tag;
  end

  assign busy_o          = 1'b0;
  assign done_o          = done_q;
  assign roll_angle_o    = roll_q;
  assign pitch_angle_o   = pitch_q;
  assign yaw_angle_o     = yaw_q;
  assign pitch_clamped_o = clamp_out_q;

endmodule
`default_nettype wire

// ===== src/q2e_isqrt.sv =====
`default_nettype none
module q2e_isqrt #(
  parameter int TAG_W = 1
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           valid_i,
  input  wire logic [q2e_pkg::RadW-1:0]       rad_i,
  input  wire logic [TAG_W-1:0]               tag_i,
  output logic                                valid_o,
  output logic [q2e_pkg::RootW-1:0]           root_o,
  output logic [TAG_W-1:0]                    tag_o
);

  localparam int Steps = q2e_pkg::SqrtSteps;
  localparam int RemW  = q2e_pkg::RemW;
  localparam int RootW = q2e_pkg::RootW;

  logic [Steps-1:0]  v_q;
  logic [RemW-1:0]   rem_q  [0:Steps-1];
  logic [RootW-1:0]  root_q [0:Steps-1];
  logic [TAG_W-1:0]  tag_q  [0:Steps-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[Steps-2:0], valid_i};
    end
  end

  for (genvar j = 0; j < Steps; j++) begin : g_step
    localparam int K = Steps - 1 - j;
    logic [RemW-1:0]  rem_src;
    logic [RootW-1:0] root_src;
    logic [TAG_W-1:0] tag_src;
    logic [RemW-1:0]  trial;

    if (j == 0) begin : g_first
      assign rem_src  = {{(RemW-q2e_pkg::RadW){1'b0}}, rad_i};
      assign root_src = '0;
      assign tag_src  = tag_i;
    end else begin : g_next
      assign rem_src  = rem_q[j-1];
      assign root_src = root_q[j-1];
      assign tag_src  = tag_q[j-1];
    end

    assign trial = ({{(RemW-RootW){1'b0}}, root_src} << (K + 1))
                 + ({{(RemW-1){1'b0}}, 1'b1} << (2 * K));

    always_ff @(posedge clk_i) begin
      tag_q[j] <= tag_src;
      if (rem_src >= trial) begin
        rem_q[j]  <= rem_src - trial;
        root_q[j] <= root_src | ({{(RootW-1){1'b0}}, 1'b1} << K);
      end else begin
        rem_q[j]  <= rem_src;
        root_q[j] <= root_src;
      end
    end
  end

  assign valid_o = v_q[Steps-1];
  assign root_o  = root_q[Steps-1];
  assign tag_o   = tag_q[Steps-1];

endmodule
`default_nettype wire

// ===== src/q2e_cordic.sv =====
`default_nettype none
module q2e_cordic #(
  parameter int STAGES = q2e_pkg::DefCordicStages,
  parameter int TAG_W  = 1
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                valid_i,
  input  wire logic signed [q2e_pkg::CordW-1:0]    y_i,
  input  wire logic signed [q2e_pkg::CordW-1:0]    x_i,
  input  wire logic [TAG_W-1:0]                    tag_i,
  output logic                                     valid_o,
  output logic signed [q2e_pkg::AngW-1:0]          angle_o,
  output logic [TAG_W-1:0]                         tag_o
);

  localparam int CordW = q2e_pkg::CordW;
  localparam int ZW    = q2e_pkg::ZW;

  logic [STAGES:0]          v_q;
  logic signed [CordW-1:0]  x_q    [0:STAGES];
  logic signed [CordW-1:0]  y_q    [0:STAGES];
  logic signed [ZW-1:0]     z_q    [0:STAGES];
  logic                     zero_q [0:STAGES];
  logic [TAG_W-1:0]         tag_q  [0:STAGES];

  logic                     x_neg;
  logic signed [ZW-1:0]     z_init;
  logic signed [ZW-1:0]     z_rnd;
  logic                     out_v_q;
  logic signed [q2e_pkg::AngW-1:0] ang_q;
  logic [TAG_W-1:0]         out_tag_q;

  assign x_neg  = x_i[CordW-1];
  assign z_init = !x_neg ? '0 : (y_i[CordW-1] ? -q2e_pkg::PiZ : q2e_pkg::PiZ);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      out_v_q <= 1'b0;
    end else begin
      v_q     <= {v_q[STAGES-1:0], valid_i};
      out_v_q <= v_q[STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    x_q[0]    <= x_neg ? -x_i : x_i;
    y_q[0]    <= x_neg ? -y_i : y_i;
    z_q[0]    <= z_init;
    zero_q[0] <= (x_i == '0) && (y_i == '0);
    tag_q[0]  <= tag_i;
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_iter
    logic signed [ZW-1:0] step_ang;
    assign step_ang = $signed({{(ZW-32){1'b0}}, q2e_pkg::atan_lut(i)});

    always_ff @(posedge clk_i) begin
      zero_q[i+1] <= zero_q[i];
      tag_q[i+1]  <= tag_q[i];
      if (!y_q[i][CordW-1] && (y_q[i] != '0)) begin
        x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] + step_ang;
      end else begin
        x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] - step_ang;
      end
    end
  end

  assign z_rnd = z_q[STAGES] + $signed({{(ZW-16){1'b0}}, 16'h8000});

  always_ff @(posedge clk_i) begin
    ang_q     <= zero_q[STAGES] ? '0 : z_rnd[ZW-1:16];
    out_tag_q <= tag_q[STAGES];
  end

  assign valid_o = out_v_q;
  assign angle_o = ang_q;
  assign tag_o   = out_tag_q;

endmodule
`default_nettype wire

// ===== src/q2e_checker.sv =====
`default_nettype none
`include "quaternion_to_euler_angles_core_defines.svh"
module q2e_checker #(
  parameter int CORDIC_STAGES = q2e_pkg::DefCordicStages
) (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              start_i,
  input wire logic                              busy_o,
  input wire logic                              done_o,
  input wire logic signed [q2e_pkg::OutW-1:0]   pitch_angle_o
);

  localparam int Lat = 38 + CORDIC_STAGES;

  `Q2E_ASSERT_IMP(a_never_busy, clk_i, rst_ni, 1'b1, !busy_o)
  `Q2E_ASSERT_IMP(a_pitch_range, clk_i, rst_ni, done_o, (pitch_angle_o <= 16'sd16384) && (pitch_angle_o >= -16'sd16384))
  `Q2E_ASSERT_DLY(a_request_done, clk_i, rst_ni, start_i && !busy_o, Lat, done_o)
  `Q2E_ASSERT_IMP(a_done_source, clk_i, rst_ni, done_o, $past(start_i && !busy_o, Lat))

endmodule

bind quaternion_to_euler_angles_core q2e_checker #(
  .CORDIC_STAGES(CORDIC_STAGES)
) u_q2e_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start_i      (start_i),
  .busy_o       (busy_o),
  .done_o       (done_o),
  .pitch_angle_o(pitch_angle_o)
);
`default_nettype wire

// ===== test/tb_quaternion_to_euler_angles_core.sv =====
`default_nettype none
module tb_quaternion_to_euler_angles_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Stages    = q2e_pkg::DefCordicStages;
  localparam int Latency   = 38 + Stages;
  localparam int NumRandom = 1400;
  localparam longint CycleLimit = 200000;

  typedef struct packed {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } quat_t;

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
    logic               clamped;
  } euler_t;

  typedef struct {
    quat_t  q;
    bit     known;
    euler_t e;
  } quat_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic signed [15:0] quat_w_i = '0, quat_x_i = '0, quat_y_i = '0, quat_z_i = '0;
  logic busy_o, done_o, pitch_clamped_o;
  logic signed [15:0] roll_angle_o, pitch_angle_o, yaw_angle_o;

  euler_t angles_due[$];
  int     error_count = 0;
  longint cycle_count = 0;

  quaternion_to_euler_angles_core #(.CORDIC_STAGES(Stages)) dut (
    .clk_i, .rst_ni, .start_i, .busy_o,
    .quat_w_i, .quat_x_i, .quat_y_i, .quat_z_i,
    .done_o, .roll_angle_o, .pitch_angle_o, .yaw_angle_o, .pitch_clamped_o
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic longint shr_arith(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint floor_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  function automatic longint angle_of(longint vy, longint vx);
    longint acc, dx, dy;
    acc = 0;
    if (vx == 0 && vy == 0) return 0;
    if (vx < 0) begin
      acc = (vy >= 0) ? (64'sd1 <<< 31) : -(64'sd1 <<< 31);
      vx = -vx;
      vy = -vy;
    end
    for (int i = 0; i < Stages && i < q2e_pkg::AtanLen; i++) begin
      dx = shr_arith(vy, i);
      dy = shr_arith(vx, i);
      if (vy > 0) begin
        vx += dx;
        vy -= dy;
        acc += longint'(q2e_pkg::atan_lut(i));
      end else begin
        vx -= dx;
        vy += dy;
        acc -= longint'(q2e_pkg::atan_lut(i));
      end
    end
    return shr_arith(acc + (64'sd1 <<< 15), 16);
  endfunction

  function automatic euler_t euler_of(quat_t q);
    longint w, x, y, z, sr, cr, sp, sy, cy, cp, p, one;
    euler_t e;
    w = q.w; x = q.x; y = q.y; z = q.z;
    one = 64'sd1 <<< 28;
    sr = 2 * (w * x + y * z);
    cr = one - 2 * (x * x + y * y);
    sp = 2 * (w * y - z * x);
    sy = 2 * (w * z + x * y);
    cy = one - 2 * (y * y + z * z);
    e.clamped = 1'b0;
    if (sp > one) begin
      sp = one;
      e.clamped = 1'b1;
    end else if (sp < -one) begin
      sp = -one;
      e.clamped = 1'b1;
    end
    cp = floor_sqrt(longint'((64'sd1 <<< 56) - sp * sp));
    p = angle_of(sp, cp);
    if (p > 16384) p = 16384;
    if (p < -16384) p = -16384;
    e.roll = 16'(angle_of(sr, cr));
    e.pitch = 16'(p);
    e.yaw = 16'(angle_of(sy, cy));
    return e;
  endfunction

  function automatic logic signed [15:0] rand_comp(int mode);
    case (mode)
      0: return 16'($urandom_range(0, 32768)) - 16'sd16384;
      1: return 16'($urandom);
      default: return ($urandom_range(0, 1)) ? 16'sh4000 : 16'shC000;
    endcase
  endfunction

  // Mixes random components with near-unit quaternions that keep the pitch term close to the clamp boundary.
  function automatic quat_t rand_quat();
    quat_t q;
    int m;
    m = $urandom_range(0, 9);
    if (m < 6) begin
      q.w = rand_comp(0); q.x = rand_comp(0); q.y = rand_comp(0); q.z = rand_comp(0);
    end else if (m < 8) begin
      q.w = rand_comp(1); q.x = rand_comp(1); q.y = rand_comp(1); q.z = rand_comp(1);
    end else begin
      q.w = 16'sd11585; q.x = 16'sd0; q.z = 16'sd0;
      q.y = ($urandom_range(0, 1) ? 16'sd11585 : -16'sd11585)
            + 16'($urandom_range(0, 8)) - 16'sd4;
      if (m == 9) q.z = rand_comp(2);
    end
    return q;
  endfunction

  task automatic issue(quat_t q);
    @(posedge clk_i);
    start_i <= 1'b1;
    quat_w_i <= q.w; quat_x_i <= q.x; quat_y_i <= q.y; quat_z_i <= q.z;
    angles_due.push_back(euler_of(q));
    do @(posedge clk_i); while (busy_o);
    start_i <= 1'b0;
  endtask

  task automatic send_quat(quat_t q, bit calm);
    if (!calm) begin
      while ($urandom_range(0, 99) < 12) begin
        start_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    start_i <= 1'b1;
    quat_w_i <= q.w; quat_x_i <= q.x; quat_y_i <= q.y; quat_z_i <= q.z;
    angles_due.push_back(euler_of(q));
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    euler_t e;
    cycle_count <= cycle_count + 1;
    if (rst_ni && done_o) begin
      if (angles_due.size() == 0) begin
        $error("result with no request outstanding");
        error_count++;
      end else begin
        e = angles_due.pop_front();
        if (roll_angle_o !== e.roll) begin
          $error("roll_angle exp %0d got %0d", e.roll, roll_angle_o);
          error_count++;
        end
        if (pitch_angle_o !== e.pitch) begin
          $error("pitch_angle exp %0d got %0d", e.pitch, pitch_angle_o);
          error_count++;
        end
        if (yaw_angle_o !== e.yaw) begin
          $error("yaw_angle exp %0d got %0d", e.yaw, yaw_angle_o);
          error_count++;
        end
        if (pitch_clamped_o !== e.clamped) begin
          $error("pitch_clamped exp %0b got %0b", e.clamped, pitch_clamped_o);
          error_count++;
        end
      end
    end
    if (cycle_count > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  quat_row_t directed[] = '{
    '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, '{16'sd0, 16'sd0, 16'sd0, 1'b0}},
    '{'{16'sd16384, 16'sd0, 16'sd0, 16'sd0}, 1'b1, '{16'sd0, 16'sd0, 16'sd0, 1'b0}},
    '{'{16'sd11585, 16'sd0, 16'sd11585, 16'sd0}, 1'b0, '0},
    '{'{16'sd11585, 16'sd0, -16'sd11585, 16'sd0}, 1'b0, '0},
    '{'{16'sd16384, 16'sd0, 16'sd16384, 16'sd0}, 1'b1,
      '{16'sh8000, 16'sd16384, 16'sh8000, 1'b1}},
    '{'{16'sd16384, 16'sd0, -16'sd16384, 16'sd0}, 1'b1,
      '{16'sh8000, -16'sd16384, 16'sh8000, 1'b1}},
    '{'{16'sd0, 16'sd16384, 16'sd0, 16'sd0}, 1'b0, '0},
    '{'{16'sd0, 16'sd0, 16'sd0, 16'sd16384}, 1'b0, '0},
    '{'{16'sd0, 16'sd0, 16'sd16384, 16'sd0}, 1'b0, '0},
    '{'{-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384}, 1'b0, '0},
    '{'{16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384}, 1'b0, '0},
    '{'{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF}, 1'b0, '0},
    '{'{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000}, 1'b0, '0},
    '{'{16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF}, 1'b0, '0},
    '{'{16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA}, 1'b0, '0},
    '{'{16'shFFFF, 16'sh0001, 16'shFFFF, 16'sh0001}, 1'b0, '0},
    '{'{16'sd0, 16'sd11585, 16'sd0, -16'sd11585}, 1'b0, '0},
    '{'{16'sd8192, -16'sd8192, 16'sd8192, 16'sd8192}, 1'b0, '0}
  };

  initial begin
    quat_row_t r;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) begin
      r = directed[i];
      if (r.known && euler_of(r.q) !== r.e) begin
        $error("predictor row %0d disagrees with typed expectation", i);
        error_count++;
      end
      send_quat(r.q, 1'b0);
    end
    start_i <= 1'b0;
    while (angles_due.size() != 0) @(posedge clk_i);
    for (int n = 0; n < NumRandom; n++) begin
      send_quat(rand_quat(), n >= 400 && n < 700);
      if (n == 900) begin
        start_i <= 1'b0;
        while (angles_due.size() != 0) @(posedge clk_i);
      end
    end
    start_i <= 1'b0;
    while (angles_due.size() != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
`default_nettype wire
